FILE: design/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_s, rst_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// Cause at one edge implies effect at the next edge.
`define ASSERT_NEXT(label, clk_s, rst_s, cause, effect, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cause) |=> (effect)) \
    else $error(msg);

`endif

FILE: design/elt_pkg.sv
// Types, constants and character helpers for the expression tokenizer.
package elt_pkg;

  localparam int unsigned MaxTokenLen  = 255;
  localparam int unsigned PositionBits = 16;
  localparam int unsigned KeywordSlots = 8;
  localparam int unsigned KeywordRegs  = 8;
  localparam int unsigned RegIndexW    = 3;
  localparam int unsigned WordW        = 64;
  localparam int unsigned PrefixChars  = 8;
  localparam int unsigned PrefixIdxW   = $clog2(PrefixChars);
  localparam int unsigned RunW         = $clog2(MaxTokenLen + 1);
  localparam int unsigned LenW         = 8;
  localparam int unsigned LenMax       = (1 << LenW) - 1;
  localparam int unsigned KwIdxW       = 3;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  typedef logic [7:0] char_t;

  localparam char_t CharSpace  = 8'h20;
  localparam char_t CharEq     = 8'h3D;
  localparam char_t CharHash   = 8'h23;
  localparam char_t CharTab    = 8'h09;
  localparam char_t CharNl     = 8'h0A;
  localparam char_t CharBslash = 8'h5C;

  typedef enum logic [4:0] {
    KIND_ADD     = 5'd0,
    KIND_MINUS   = 5'd1,
    KIND_TIMES   = 5'd2,
    KIND_DIV     = 5'd3,
    KIND_MOD     = 5'd4,
    KIND_ASSIGN  = 5'd5,
    KIND_EQ      = 5'd6,
    KIND_GREATER = 5'd7,
    KIND_LESS    = 5'd8,
    KIND_COLON   = 5'd9,
    KIND_COMMA   = 5'd10,
    KIND_LPAREN  = 5'd11,
    KIND_RPAREN  = 5'd12,
    KIND_LBRACK  = 5'd13,
    KIND_RBRACK  = 5'd14,
    KIND_LBRACE  = 5'd15,
    KIND_RBRACE  = 5'd16,
    KIND_DOT     = 5'd17,
    KIND_QUOTE   = 5'd18,
    KIND_END     = 5'd19,
    KIND_TAB     = 5'd20,
    KIND_EOL     = 5'd21,
    KIND_NUMBER  = 5'd22,
    KIND_IDENT   = 5'd23,
    KIND_STRING  = 5'd24,
    KIND_KEYWORD = 5'd25,
    KIND_EMPTY   = 5'd26
  } kind_t;

  typedef enum logic [3:0] {
    PEND_NONE = 4'b0001,
    PEND_NUM  = 4'b0010,
    PEND_WORD = 4'b0100,
    PEND_EQ   = 4'b1000
  } pend_t;

  // Slot a: token closed by the character; slot b: token the character makes itself.
  typedef struct packed {
    logic                    a_valid;
    kind_t                   a_kind;
    logic                    a_word;
    logic                    a_bs;
    logic [WordW-1:0]        a_prefix;
    logic [RunW-1:0]         a_len;
    logic [PositionBits-1:0] a_start;
    logic                    b_valid;
    kind_t                   b_kind;
    logic [PositionBits-1:0] b_start;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } single_t;

  function automatic logic is_digit(char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(char_t c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic single_t single_kind(char_t c);
    single_t r;
    r.hit  = 1'b1;
    r.kind = KIND_EMPTY;
    unique case (c)
      8'h2B:    r.kind = KIND_ADD;
      8'h2D:    r.kind = KIND_MINUS;
      8'h2A:    r.kind = KIND_TIMES;
      8'h2F:    r.kind = KIND_DIV;
      8'h25:    r.kind = KIND_MOD;
      8'h3E:    r.kind = KIND_GREATER;
      8'h3C:    r.kind = KIND_LESS;
      8'h3A:    r.kind = KIND_COLON;
      8'h2C:    r.kind = KIND_COMMA;
      8'h28:    r.kind = KIND_LPAREN;
      8'h29:    r.kind = KIND_RPAREN;
      8'h5B:    r.kind = KIND_LBRACK;
      8'h5D:    r.kind = KIND_RBRACK;
      8'h7B:    r.kind = KIND_LBRACE;
      8'h7D:    r.kind = KIND_RBRACE;
      8'h2E:    r.kind = KIND_DOT;
      8'h22:    r.kind = KIND_QUOTE;
      CharHash: r.kind = KIND_END;
      CharTab:  r.kind = KIND_TAB;
      CharNl:   r.kind = KIND_EOL;
      default:  r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [LenW-1:0] sat_len(logic [RunW-1:0] n);
    if (int'(n) > int'(LenMax)) begin
      return LenW'(LenMax);
    end
    return LenW'(n);
  endfunction

endpackage

FILE: design/elt_front.sv
// Front end: takes characters, tracks the pending run and queues finished token slots.
`include "assert_macros.svh"

module elt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  elt_pkg::char_t               char_code,
  input  elt_pkg::q_status_t           q_status,
  output logic                         q_push,
  output elt_pkg::entry_t              q_entry
);

  elt_pkg::pend_t                          pend, pend_next;
  logic [elt_pkg::WordW-1:0]               prefix, prefix_next;
  logic [elt_pkg::RunW-1:0]                run_len, run_len_next;
  logic [elt_pkg::PositionBits-1:0]        run_start, run_start_next;
  logic [elt_pkg::PositionBits-1:0]        char_pos, char_pos_next;
  logic                                    saw_bs, saw_bs_next;
  logic                                    accept;
  logic                                    classify;
  logic                                    c_digit, c_letter, c_bs;
  elt_pkg::single_t                        sk;
  elt_pkg::entry_t                         ent;

  assign accept   = push && !q_status.full;
  assign c_digit  = elt_pkg::is_digit(char_code);
  assign c_letter = elt_pkg::is_letter(char_code);
  assign c_bs     = (char_code == elt_pkg::CharBslash);
  assign sk       = elt_pkg::single_kind(char_code);

  always_comb begin
    pend_next      = pend;
    prefix_next    = prefix;
    run_len_next   = run_len;
    run_start_next = run_start;
    char_pos_next  = char_pos;
    saw_bs_next    = saw_bs;
    classify       = 1'b1;
    ent            = '0;
    ent.a_kind     = elt_pkg::KIND_EMPTY;
    ent.b_kind     = elt_pkg::KIND_EMPTY;
    ent.a_prefix   = prefix;
    ent.a_bs       = saw_bs;
    ent.a_len      = run_len;
    ent.a_start    = run_start;
    ent.b_start    = char_pos;
    if (accept) begin
      char_pos_next = char_pos + 1'b1;
      unique case (pend)
        elt_pkg::PEND_NUM, elt_pkg::PEND_WORD: begin
          if (c_digit || ((pend == elt_pkg::PEND_WORD) && (c_letter || c_bs))) begin
            // extend the run; only the first characters feed the keyword compare
            if (run_len < elt_pkg::RunW'(elt_pkg::PrefixChars)) begin
              prefix_next[run_len[elt_pkg::PrefixIdxW-1:0]*8 +: 8] = char_code;
            end
            if (run_len < elt_pkg::RunW'(elt_pkg::MaxTokenLen)) begin
              run_len_next = run_len + 1'b1;
            end
            if (c_bs) begin
              saw_bs_next = 1'b1;
            end
            classify = 1'b0;
          end else begin
            ent.a_valid = 1'b1;
            ent.a_word  = (pend == elt_pkg::PEND_WORD);
            ent.a_kind  = (pend == elt_pkg::PEND_WORD) ? elt_pkg::KIND_IDENT
                                                       : elt_pkg::KIND_NUMBER;
            pend_next   = elt_pkg::PEND_NONE;
          end
        end
        elt_pkg::PEND_EQ: begin
          pend_next   = elt_pkg::PEND_NONE;
          ent.a_valid = 1'b1;
          if (char_code == elt_pkg::CharEq) begin
            ent.a_kind = elt_pkg::KIND_EQ;
            ent.a_len  = elt_pkg::RunW'(2);
            classify   = 1'b0;
          end else begin
            ent.a_kind = elt_pkg::KIND_ASSIGN;
            ent.a_len  = elt_pkg::RunW'(1);
          end
        end
        default: ;
      endcase
      if (classify) begin
        if (char_code == elt_pkg::CharSpace) begin
          // skip
        end else if (sk.hit) begin
          ent.b_valid = 1'b1;
          ent.b_kind  = sk.kind;
        end else if (char_code == elt_pkg::CharEq) begin
          pend_next      = elt_pkg::PEND_EQ;
          run_start_next = char_pos;
          run_len_next   = elt_pkg::RunW'(1);
          prefix_next    = '0;
          saw_bs_next    = 1'b0;
        end else if (c_digit || c_letter || c_bs) begin
          pend_next      = c_digit ? elt_pkg::PEND_NUM : elt_pkg::PEND_WORD;
          prefix_next    = elt_pkg::WordW'(char_code);
          run_len_next   = elt_pkg::RunW'(1);
          run_start_next = char_pos;
          saw_bs_next    = c_bs;
        end else begin
          ent.b_valid = 1'b1;
          ent.b_kind  = elt_pkg::KIND_EMPTY;
        end
      end
    end
  end

  assign q_push  = accept && (ent.a_valid || ent.b_valid);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= elt_pkg::PEND_NONE;
      prefix    <= '0;
      run_len   <= '0;
      run_start <= '0;
      char_pos  <= '0;
      saw_bs    <= 1'b0;
    end else begin
      pend      <= pend_next;
      prefix    <= prefix_next;
      run_len   <= run_len_next;
      run_start <= run_start_next;
      char_pos  <= char_pos_next;
      saw_bs    <= saw_bs_next;
    end
  end

  `ASSERT_ALWAYS(a_eq_len_one, clk, rst,
    (pend != elt_pkg::PEND_EQ) || (run_len == elt_pkg::RunW'(1)),
    "pending equals sign with run length other than one")
  `ASSERT_ALWAYS(a_no_push_when_full, clk, rst,
    !(q_push && q_status.full),
    "token slots queued while the queue is full")

endmodule

FILE: design/elt_queue.sv
// Short queue of token slot entries between front and back ends.
`include "assert_macros.svh"

module elt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  elt_pkg::entry_t    push_entry,
  input  logic               pop,
  output elt_pkg::entry_t    head,
  output elt_pkg::q_status_t status
);

  elt_pkg::entry_t                   mem [elt_pkg::QueueDepth];
  logic [elt_pkg::QueuePtrW-1:0]     wr_ptr, rd_ptr;
  logic [elt_pkg::QueueCntW-1:0]     count;
  logic                              do_push, do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == elt_pkg::QueueCntW'(elt_pkg::QueueDepth));
  assign head         = mem[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst,
    count <= elt_pkg::QueueCntW'(elt_pkg::QueueDepth),
    "queue count above depth")
  `ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop,
    count == $past(count) + 1'b1,
    "queue count did not advance on transfer in")

endmodule

FILE: design/elt_back.sv
// Back end: keyword registers, keyword match and the result output register.
`include "assert_macros.svh"

module elt_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [elt_pkg::RegIndexW-1:0]     reg_index,
  input  logic [elt_pkg::WordW-1:0]         write_data,
  input  elt_pkg::entry_t                   head,
  input  elt_pkg::q_status_t                q_status,
  output logic                              q_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic [4:0]                        token_kind,
  output logic [elt_pkg::KwIdxW-1:0]        keyword_index,
  output logic [elt_pkg::LenW-1:0]          token_length,
  output logic [elt_pkg::PositionBits-1:0]  token_start,
  output logic                              last_of_run
);

  logic [elt_pkg::WordW-1:0]         kw [elt_pkg::KeywordRegs];
  logic                              phase;
  logic                              out_valid;
  logic                              use_a, is_last, load;
  logic                              kw_hit;
  logic [elt_pkg::KwIdxW-1:0]        kw_idx;
  elt_pkg::kind_t                    cur_kind;
  elt_pkg::kind_t                    out_kind;
  logic [elt_pkg::KwIdxW-1:0]        cur_idx;
  logic [elt_pkg::LenW-1:0]          cur_len;
  logic [elt_pkg::PositionBits-1:0]  cur_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(elt_pkg::KeywordRegs); i++) begin
        kw[i] <= '0;
      end
    end else if (write_enable) begin
      kw[reg_index] <= write_data;
    end
  end

  // lowest matching slot wins
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = int'(elt_pkg::KeywordSlots) - 1; i >= 0; i--) begin
      if ((kw[i] != '0) && (kw[i] == head.a_prefix)) begin
        kw_hit = 1'b1;
        kw_idx = elt_pkg::KwIdxW'(i);
      end
    end
  end

  always_comb begin
    use_a     = !phase && head.a_valid;
    is_last   = !use_a || !head.b_valid;
    cur_kind  = head.b_kind;
    cur_idx   = '0;
    cur_len   = elt_pkg::LenW'(1);
    cur_start = head.b_start;
    if (use_a) begin
      cur_kind  = head.a_kind;
      cur_len   = elt_pkg::sat_len(head.a_len);
      cur_start = head.a_start;
      if (head.a_word) begin
        if (head.a_bs) begin
          cur_kind = elt_pkg::KIND_STRING;
        end else if (kw_hit && (head.a_len <= elt_pkg::RunW'(elt_pkg::PrefixChars))) begin
          cur_kind = elt_pkg::KIND_KEYWORD;
          cur_idx  = kw_idx;
        end else begin
          cur_kind = elt_pkg::KIND_IDENT;
        end
      end
    end
  end

  assign load  = !q_status.empty && (!out_valid || pop);
  assign q_pop = load && is_last;
  assign empty = !out_valid;
  assign token_kind = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !is_last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind      <= cur_kind;
      keyword_index <= cur_idx;
      token_length  <= cur_len;
      token_start   <= cur_start;
      last_of_run   <= is_last;
    end
  end

  `ASSERT_ALWAYS(a_phase_has_b, clk, rst,
    !phase || (!q_status.empty && head.b_valid && head.a_valid),
    "second slot phase without a two-token entry at the head")

endmodule

FILE: design/expression_lexer_tokenizer.sv
// Tokens a character closes are queued, then loaded into the output register when it frees.
// Throughput: one character per cycle unless full; output drains one token per cycle while
//   pop is held; a two-token character gives both in turn (four-entry queue absorbs bursts).
// Per-cycle limit is the keyword match: eight 64-bit equality compares and a priority pick.
// Reset (synchronous, active high) drops any pending token, zeroes the position counter,
//   clears all keyword registers and empties the queue and output register.
module expression_lexer_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        char_code,
  output logic                              empty,
  input  logic                              pop,
  output logic [4:0]                        token_kind,
  output logic [elt_pkg::KwIdxW-1:0]        keyword_index,
  output logic [elt_pkg::LenW-1:0]          token_length,
  output logic [elt_pkg::PositionBits-1:0]  token_start,
  output logic                              last_of_run,
  input  logic                              write_enable,
  input  logic [elt_pkg::RegIndexW-1:0]     reg_index,
  input  logic [elt_pkg::WordW-1:0]         write_data
);

  elt_pkg::q_status_t q_status;
  elt_pkg::entry_t    q_entry;
  elt_pkg::entry_t    q_head;
  logic               q_push;
  logic               q_pop;

  assign full = q_status.full;

  elt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  elt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  elt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .head          (q_head),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .token_kind    (token_kind),
    .keyword_index (keyword_index),
    .token_length  (token_length),
    .token_start   (token_start),
    .last_of_run   (last_of_run)
  );

endmodule

FILE: verif/tb_expression_lexer_tokenizer.sv
// Self-checking testbench for the expression tokenizer: directed table, then random character streams.
`timescale 1ns / 1ps

module tb_expression_lexer_tokenizer;

  localparam int DirectedRows  = 27;
  localparam int PhaseCount    = 5;
  localparam int RandomItems   = 200;
  localparam int MaxGap        = 16;
  localparam int HoldCycles    = 80;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 1000;

  typedef struct packed {
    elt_pkg::kind_t                   kind;
    logic [elt_pkg::KwIdxW-1:0]       idx;
    logic [elt_pkg::LenW-1:0]         len;
    logic [elt_pkg::PositionBits-1:0] start;
    logic                             last;
  } token_t;

  typedef token_t [1:0] token_pair_t;

  typedef struct packed {
    elt_pkg::char_t                   ch;
    logic                             typed;
    elt_pkg::kind_t                   kind;
    logic [elt_pkg::LenW-1:0]         len;
    logic [elt_pkg::PositionBits-1:0] start;
  } stim_row_t;

  typedef enum logic [1:0] {OPEN_NONE, OPEN_NUMBER, OPEN_WORD, OPEN_EQUAL} open_run_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             full;
  logic [7:0]                       char_code = '0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic [4:0]                       token_kind;
  logic [elt_pkg::KwIdxW-1:0]       keyword_index;
  logic [elt_pkg::LenW-1:0]         token_length;
  logic [elt_pkg::PositionBits-1:0] token_start;
  logic                             last_of_run;
  logic                             write_enable = 1'b0;
  logic [elt_pkg::RegIndexW-1:0]    reg_index = '0;
  logic [elt_pkg::WordW-1:0]        write_data = '0;

  // Tokenizer state as seen by the predictor
  open_run_t                        open_run = OPEN_NONE;
  logic [elt_pkg::WordW-1:0]        run_prefix = '0;
  int unsigned                      run_len = 0;
  logic [elt_pkg::PositionBits-1:0] run_first = '0;
  logic [elt_pkg::PositionBits-1:0] char_pos = '0;
  bit                               run_has_bslash = 1'b0;
  logic [elt_pkg::WordW-1:0]        kw_regs [elt_pkg::KeywordRegs] = '{default: '0};

  token_t tokens_due[$];
  int     errors = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     hold_requests = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  string  punct_chars = "+-*/%><:,()[]{}.\"#\t\n";

  int send_idle_pct  [PhaseCount] = '{0, 67, 0, 13, 0};
  int recv_stall_pct [PhaseCount] = '{0, 0, 67, 13, 0};

  string keyword_sets [PhaseCount][elt_pkg::KeywordRegs] = '{
    '{"if", "else", "while", "for", "do", "return", "int", "abcdefgh"},
    '{"", "x", "x", "Ab1", "a\\b", "zzzzzzzz", "", "Q"},
    '{"", "", "", "", "", "", "", ""},
    '{"if", "if", "then", "go", "to", "goto", "x1", "end"},
    '{"if", "else", "while", "for", "do", "return", "int", "abcdefgh"}
  };

  // Positions count from reset; only single-result rows carry a typed token.
  stim_row_t directed_rows [DirectedRows] = '{
    '{8'h00,               1'b1, elt_pkg::KIND_EMPTY,  8'd1, 16'd0},
    '{8'hFF,               1'b1, elt_pkg::KIND_EMPTY,  8'd1, 16'd1},
    '{"+",                 1'b1, elt_pkg::KIND_ADD,    8'd1, 16'd2},
    '{elt_pkg::CharHash,   1'b1, elt_pkg::KIND_END,    8'd1, 16'd3},
    '{elt_pkg::CharTab,    1'b1, elt_pkg::KIND_TAB,    8'd1, 16'd4},
    '{elt_pkg::CharNl,     1'b1, elt_pkg::KIND_EOL,    8'd1, 16'd5},
    '{elt_pkg::CharEq,     1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{elt_pkg::CharEq,     1'b1, elt_pkg::KIND_EQ,     8'd2, 16'd6},
    '{elt_pkg::CharEq,     1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{elt_pkg::CharSpace,  1'b1, elt_pkg::KIND_ASSIGN, 8'd1, 16'd8},
    '{elt_pkg::CharEq,     1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{elt_pkg::CharEq,     1'b1, elt_pkg::KIND_EQ,     8'd2, 16'd10},
    '{elt_pkg::CharEq,     1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"1",                 1'b1, elt_pkg::KIND_ASSIGN, 8'd1, 16'd12},
    '{"2",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"a",                 1'b1, elt_pkg::KIND_NUMBER, 8'd2, 16'd13},
    '{"b",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"(",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"i",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"f",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{")",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"a",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{elt_pkg::CharBslash, 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"9",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"~",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"0",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0},
    '{"*",                 1'b0, elt_pkg::KIND_EMPTY,  8'd0, 16'd0}
  };

  expression_lexer_tokenizer i_dut (
    .clk, .rst, .push, .full, .char_code, .empty, .pop,
    .token_kind, .keyword_index, .token_length, .token_start, .last_of_run,
    .write_enable, .reg_index, .write_data
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic bit is_dec(input elt_pkg::char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_alpha(input elt_pkg::char_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic bit punct_kind(input elt_pkg::char_t c, output elt_pkg::kind_t k);
    k = elt_pkg::KIND_EMPTY;
    case (c)
      "+":               k = elt_pkg::KIND_ADD;
      "-":               k = elt_pkg::KIND_MINUS;
      "*":               k = elt_pkg::KIND_TIMES;
      "/":               k = elt_pkg::KIND_DIV;
      "%":               k = elt_pkg::KIND_MOD;
      ">":               k = elt_pkg::KIND_GREATER;
      "<":               k = elt_pkg::KIND_LESS;
      ":":               k = elt_pkg::KIND_COLON;
      ",":               k = elt_pkg::KIND_COMMA;
      "(":               k = elt_pkg::KIND_LPAREN;
      ")":               k = elt_pkg::KIND_RPAREN;
      "[":               k = elt_pkg::KIND_LBRACK;
      "]":               k = elt_pkg::KIND_RBRACK;
      "{":               k = elt_pkg::KIND_LBRACE;
      "}":               k = elt_pkg::KIND_RBRACE;
      ".":               k = elt_pkg::KIND_DOT;
      "\"":              k = elt_pkg::KIND_QUOTE;
      elt_pkg::CharHash: k = elt_pkg::KIND_END;
      elt_pkg::CharTab:  k = elt_pkg::KIND_TAB;
      elt_pkg::CharNl:   k = elt_pkg::KIND_EOL;
      default:           return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic token_t make_token(input elt_pkg::kind_t k,
                                        input logic [elt_pkg::KwIdxW-1:0] idx,
                                        input int unsigned len,
                                        input logic [elt_pkg::PositionBits-1:0] start);
    token_t t;
    t.kind  = k;
    t.idx   = idx;
    t.len   = (len > elt_pkg::LenMax) ? elt_pkg::LenW'(elt_pkg::LenMax)
                                      : elt_pkg::LenW'(len);
    t.start = start;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic void begin_run(input open_run_t r, input elt_pkg::char_t c,
                                    input logic [elt_pkg::PositionBits-1:0] at);
    open_run       = r;
    run_prefix     = elt_pkg::WordW'(c);
    run_len        = 1;
    run_first      = at;
    run_has_bslash = (c == elt_pkg::CharBslash);
  endfunction

  function automatic void grow_run(input elt_pkg::char_t c);
    if (run_len < elt_pkg::PrefixChars) run_prefix[8*run_len +: 8] = c;
    if (run_len < elt_pkg::MaxTokenLen) run_len++;
    if (c == elt_pkg::CharBslash) run_has_bslash = 1'b1;
  endfunction

  // Advance the tokenizer by one character and return the tokens it completes.
  function automatic void lex_char(input elt_pkg::char_t c, output token_pair_t toks,
                                   output int n);
    logic [elt_pkg::PositionBits-1:0] here;
    elt_pkg::kind_t                   k;
    logic [elt_pkg::KwIdxW-1:0]       idx;
    here     = char_pos;
    char_pos = char_pos + 1'b1;
    toks     = '0;
    n        = 0;
    case (open_run)
      OPEN_NUMBER: begin
        if (is_dec(c)) begin
          grow_run(c);
          return;
        end
        toks[n] = make_token(elt_pkg::KIND_NUMBER, '0, run_len, run_first);
        n++;
        open_run = OPEN_NONE;
      end
      OPEN_WORD: begin
        if (is_alpha(c) || is_dec(c) || c == elt_pkg::CharBslash) begin
          grow_run(c);
          return;
        end
        k   = elt_pkg::KIND_IDENT;
        idx = '0;
        if (run_has_bslash) begin
          k = elt_pkg::KIND_STRING;
        end else if (run_len <= elt_pkg::PrefixChars) begin
          // scan downward so the lowest matching slot wins
          for (int i = elt_pkg::KeywordSlots - 1; i >= 0; i--) begin
            if (kw_regs[i] != '0 && kw_regs[i] == run_prefix) begin
              k   = elt_pkg::KIND_KEYWORD;
              idx = elt_pkg::KwIdxW'(i);
            end
          end
        end
        toks[n] = make_token(k, idx, run_len, run_first);
        n++;
        open_run = OPEN_NONE;
      end
      OPEN_EQUAL: begin
        open_run = OPEN_NONE;
        if (c == elt_pkg::CharEq) begin
          toks[0]      = make_token(elt_pkg::KIND_EQ, '0, 2, run_first);
          toks[0].last = 1'b1;
          n            = 1;
          return;
        end
        toks[n] = make_token(elt_pkg::KIND_ASSIGN, '0, 1, run_first);
        n++;
      end
      default: ;
    endcase

    if (c == elt_pkg::CharSpace) begin
      // skip
    end else if (punct_kind(c, k)) begin
      toks[n] = make_token(k, '0, 1, here);
      n++;
    end else if (c == elt_pkg::CharEq) begin
      open_run       = OPEN_EQUAL;
      run_first      = here;
      run_len        = 1;
      run_prefix     = '0;
      run_has_bslash = 1'b0;
    end else if (is_dec(c)) begin
      begin_run(OPEN_NUMBER, c, here);
    end else if (is_alpha(c) || c == elt_pkg::CharBslash) begin
      begin_run(OPEN_WORD, c, here);
    end else begin
      toks[n] = make_token(elt_pkg::KIND_EMPTY, '0, 1, here);
      n++;
    end
    if (n > 0) toks[n-1].last = 1'b1;
  endfunction

  function automatic logic [elt_pkg::WordW-1:0] pack_word(input string s);
    logic [elt_pkg::WordW-1:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < elt_pkg::PrefixChars; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  // Letter, digit or backslash; a leading byte is never a digit.
  function automatic elt_pkg::char_t word_byte(input bit lead);
    int r;
    r = lead ? $urandom_range(52) : $urandom_range(62);
    if (r < 26) return elt_pkg::char_t'("a" + r);
    if (r < 52) return elt_pkg::char_t'("A" + r - 26);
    if (lead || r == 62) return elt_pkg::CharBslash;
    return elt_pkg::char_t'("0" + r - 52);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Offer one character, wait for its transfer, then queue the tokens it completes or the typed token.
  task automatic feed(input elt_pkg::char_t c, input bit typed, input token_t typed_tok);
    token_pair_t toks;
    int          n;
    int          gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    lex_char(c, toks, n);
    if (typed) begin
      tokens_due.push_back(typed_tok);
    end else begin
      for (int i = 0; i < n; i++) tokens_due.push_back(toks[i]);
    end
  endtask

  task automatic load_keywords(input logic [elt_pkg::WordW-1:0] words [elt_pkg::KeywordRegs]);
    for (int s = 0; s < elt_pkg::KeywordRegs; s++) begin
      write_enable <= 1'b1;
      reg_index    <= elt_pkg::RegIndexW'(s);
      write_data   <= words[s];
      kw_regs[s]    = words[s];
      @(posedge clk);
    end
    write_enable <= 1'b0;
  endtask

  // Close any pending run, drain every token, then let the pipeline go quiet.
  task automatic settle();
    feed(elt_pkg::CharSpace, 1'b0, '0);
    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic long_run(input bit digits, input int len);
    for (int j = 0; j < len; j++) begin
      feed(digits ? elt_pkg::char_t'("0" + $urandom_range(9)) : word_byte(j == 0),
           1'b0, '0);
    end
    feed("+", 1'b0, '0);
  endtask

  task automatic random_stream(input int count);
    elt_pkg::char_t            burst[$];
    int                        sent;
    int                        pick;
    int                        len;
    logic [elt_pkg::WordW-1:0] w;
    sent = 0;
    while (sent < count) begin
      burst.delete();
      pick = $urandom_range(99);
      if (pick < 30) begin
        w = kw_regs[$urandom_range(elt_pkg::KeywordRegs - 1)];
        if ($urandom_range(2) == 0 && w != '0) begin
          for (int j = 0; j < elt_pkg::PrefixChars; j++) begin
            if (w[8*j +: 8] == '0) break;
            burst.push_back(w[8*j +: 8]);
          end
          // sometimes stretch a keyword by one so it must not match
          if ($urandom_range(2) == 0) burst.push_back(word_byte(1'b0));
        end else begin
          len = $urandom_range(10, 1);
          for (int j = 0; j < len; j++) burst.push_back(word_byte(j == 0));
        end
      end else if (pick < 50) begin
        len = $urandom_range(5, 1);
        for (int j = 0; j < len; j++) begin
          burst.push_back(elt_pkg::char_t'("0" + $urandom_range(9)));
        end
      end else if (pick < 70) begin
        burst.push_back(punct_chars[$urandom_range(punct_chars.len() - 1)]);
      end else if (pick < 80) begin
        len = $urandom_range(3, 1);
        for (int j = 0; j < len; j++) burst.push_back(elt_pkg::CharEq);
      end else if (pick < 90) begin
        len = $urandom_range(2, 1);
        for (int j = 0; j < len; j++) burst.push_back(elt_pkg::CharSpace);
      end else begin
        burst.push_back(elt_pkg::char_t'($urandom_range(255)));
      end
      foreach (burst[i]) begin
        feed(burst[i], 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst && pop && !empty) begin
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: token with no expectation: kind %0d, start %0d",
                 $time, token_kind, token_start);
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", want.kind, token_kind);
        check_field("keyword_index", want.idx, keyword_index);
        check_field("token_length", want.len, token_length);
        check_field("token_start", want.start, token_start);
        check_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [elt_pkg::WordW-1:0] words [elt_pkg::KeywordRegs];
    token_t                    typed_tok;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // duplicate keyword in slots 0 and 3, all-ones word in the top slot
    words    = '{default: '0};
    words[0] = pack_word("if");
    words[3] = pack_word("if");
    words[7] = '1;
    load_keywords(words);

    foreach (directed_rows[r]) begin
      typed_tok = '{kind: directed_rows[r].kind, idx: '0, len: directed_rows[r].len,
                    start: directed_rows[r].start, last: 1'b1};
      feed(directed_rows[r].ch, directed_rows[r].typed, typed_tok);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle();
      for (int s = 0; s < elt_pkg::KeywordRegs; s++) begin
        words[s] = pack_word(keyword_sets[ph][s]);
      end
      load_keywords(words);
      send_idle  = send_idle_pct[ph];
      recv_stall = recv_stall_pct[ph];
      if (ph == PhaseCount - 1) hold_requests++;
      if (ph == 0) long_run(1'b0, 260);
      if (ph == 2) long_run(1'b1, 258);
      random_stream(RandomItems);
    end
    settle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/elt_pkg.sv
design/elt_front.sv
design/elt_queue.sv
design/elt_back.sv
design/expression_lexer_tokenizer.sv
verif/tb_expression_lexer_tokenizer.sv
